### rtl/edge_gated_max_gradient_blur_defines.svh
// Assertion macros for the edge-gated blur score RTL.
// Included by the top level, which checks its own logic; depends on nothing.
`ifndef EDGE_GATED_MAX_GRADIENT_BLUR_DEFINES_SVH
`define EDGE_GATED_MAX_GRADIENT_BLUR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EGMGB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("egmgb assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EGMGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("egmgb assertion failed");

`endif

### rtl/egmgb_pkg.sv
// Package for the edge-gated blur score block: widths, reset values and the
// window structure passed to the score unit. Depends on nothing.
package egmgb_pkg;

   localparam int GRAY_W            = 8;
   localparam int PIX_W             = GRAY_W + 1;   // edge flag above the gray value
   localparam int SCORE_W           = 7;
   localparam int CSR_W             = 13;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int MIN_LINE_WIDTH    = 2;
   localparam logic [CSR_W-1:0] LINE_WIDTH_RESET = CSR_W'(640);

   // Reciprocal of three for 8-bit operands: floor(x / 3) == (x * 171) >> 9.
   localparam int RECIP3_MUL   = 171;
   localparam int RECIP3_SHIFT = 9;

   typedef struct packed {
      logic [PIX_W-1:0] tl;
      logic [PIX_W-1:0] tr;
      logic [PIX_W-1:0] bl;
      logic [PIX_W-1:0] br;
   } window_type;

   typedef struct packed {
      logic               hit;     // all edge flags of the window set
      logic [SCORE_W-1:0] score;
   } score_type;

endpackage

### rtl/egmgb_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; contents are undefined until written.
module egmgb_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/egmgb_score.sv
// Score of one 2x2 window: edge gating and the largest of the halved vertical
// and horizontal differences and the diagonal difference over three.
// Depends on egmgb_pkg.
module egmgb_score
   import egmgb_pkg::*;
(
   input  window_type win,
   output score_type  result
);

   logic [GRAY_W-1:0]    diff_v;
   logic [GRAY_W-1:0]    diff_h;
   logic [GRAY_W-1:0]    diff_d;
   logic [SCORE_W-1:0]   half_v;
   logic [SCORE_W-1:0]   half_h;
   logic [GRAY_W+GRAY_W-1:0] prod_d;
   logic [SCORE_W-1:0]   third_d;
   logic [SCORE_W-1:0]   best_vh;

   always_comb begin
      diff_v = (win.tl[GRAY_W-1:0] > win.bl[GRAY_W-1:0]) ?
               win.tl[GRAY_W-1:0] - win.bl[GRAY_W-1:0] :
               win.bl[GRAY_W-1:0] - win.tl[GRAY_W-1:0];
      diff_h = (win.tl[GRAY_W-1:0] > win.tr[GRAY_W-1:0]) ?
               win.tl[GRAY_W-1:0] - win.tr[GRAY_W-1:0] :
               win.tr[GRAY_W-1:0] - win.tl[GRAY_W-1:0];
      diff_d = (win.tl[GRAY_W-1:0] > win.br[GRAY_W-1:0]) ?
               win.tl[GRAY_W-1:0] - win.br[GRAY_W-1:0] :
               win.br[GRAY_W-1:0] - win.tl[GRAY_W-1:0];

      half_v  = diff_v[GRAY_W-1:1];
      half_h  = diff_h[GRAY_W-1:1];
      prod_d  = (GRAY_W+GRAY_W)'(diff_d) * (GRAY_W+GRAY_W)'(RECIP3_MUL);
      third_d = SCORE_W'(prod_d >> RECIP3_SHIFT);

      best_vh = (half_h > half_v) ? half_h : half_v;
      result.score = (third_d > best_vh) ? third_d : best_vh;
      result.hit   = win.tl[PIX_W-1] & win.tr[PIX_W-1] &
                     win.bl[PIX_W-1] & win.br[PIX_W-1];
   end

endmodule

### rtl/edge_gated_max_gradient_blur.sv
// Edge-gated maximum-gradient blur score, top level.
// Depends on egmgb_pkg, egmgb_ram, egmgb_score and the assertion macro header.
//
// Usage:
// The req channel carries one pixel item per handshake: the gray value in
// req_tdata, the edge flag in req_tuser and the end-of-frame mark in req_tlast.
// Pixels arrive in raster order in rows of csr_wr_data pixels (clamped to the
// range 2 to MAX_WIDTH). The user must write the row width through csr_wr_en
// only while the block is idle; the block itself does not enforce this. The rsp
// channel carries one item per frame, the largest gated window score of that
// frame, registered when its last pixel retires from the compare stage. Every
// other pixel produces no result. The block accepts one pixel per clock while
// req_tready is high. The line buffer RAM is read when a pixel is accepted and
// written when it retires from the compare stage, through separate read and write ports.
// When a frame ends on the first column, the next pixel reads the entry that
// is being written in the same cycle, and the written value is forwarded.
// Reset clears the column count, the row flag, the running maximum and the
// pipeline; the line buffer itself is not cleared. If a result waits on rsp
// with rsp_tready low, pixels keep flowing until the next frame-end pixel
// reaches the compare stage, which then holds req_tready low.
`include "edge_gated_max_gradient_blur_defines.svh"

module edge_gated_max_gradient_blur
   import egmgb_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic             clock,
   input  logic             reset,
   // Pixel input channel.
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,    // [7:0] gray_pixel
   input  logic             req_tuser,    // [0] edge_flag
   input  logic             req_tlast,    // frame_end
   // Score output channel.
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,    // [6:0] blur_score, [7] zero
   // Row width register.
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WW > CSR_W) ? WW : CSR_W;

   // Configuration and the clamped row width.
   logic [CMP_W-1:0] width_eff_ff;
   logic [CMP_W-1:0] width_eff_in;

   // Accept-side column tracking.
   logic [AW-1:0]    col_ff;
   logic [AW-1:0]    col_in;
   logic             row_ff;       // past the first row of the frame
   logic             row_in;
   logic [CMP_W-1:0] col_next;

   // Compare stage: one pixel whose line buffer read is in flight.
   logic             s1_valid_ff;
   logic [AW-1:0]    s1_col_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic             s1_last_ff;
   logic             s1_row_ff;
   logic             s1_adv;
   logic             s1_fire;

   // Window neighbors and the frame maximum.
   logic [PIX_W-1:0]   ul_ff;
   logic [PIX_W-1:0]   ll_ff;
   logic [SCORE_W-1:0] max_ff;
   logic [SCORE_W-1:0] max_in;

   // Line buffer and write forwarding.
   logic             accept;
   logic [PIX_W-1:0] ram_rd_data;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_data_ff;
   logic [PIX_W-1:0] up_pix;
   logic             same_addr;

   // Output register.
   logic               out_valid_ff;
   logic [SCORE_W-1:0] out_score_ff;

   window_type win;
   score_type  win_score;

   // The clamp is applied as the register is written, so a pixel accepted
   // right after a write already uses the new row width.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_eff_ff <= CMP_W'(LINE_WIDTH_RESET);
      end else if (csr_wr_en) begin
         width_eff_ff <= width_eff_in;
      end
   end

   always_comb begin
      if (CMP_W'(csr_wr_data) < CMP_W'(MIN_LINE_WIDTH)) begin
         width_eff_in = CMP_W'(MIN_LINE_WIDTH);
      end else if (CMP_W'(csr_wr_data) > CMP_W'(MAX_WIDTH)) begin
         width_eff_in = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff_in = CMP_W'(csr_wr_data);
      end
   end

   // The compare stage only stalls when it holds a frame end and the output
   // register still holds an unread score.
   assign s1_adv     = !s1_valid_ff || !s1_last_ff || !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_adv;
   assign req_tready = s1_adv;
   assign accept     = req_tvalid && s1_adv;

   // Column count and row flag advance at accept; a frame end restarts both.
   always_comb begin
      col_next = CMP_W'(col_ff) + CMP_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (req_tlast) begin
            col_in = '0;
            row_in = 1'b0;
         end else if (col_next >= width_eff_ff) begin
            col_in = '0;
            row_in = 1'b1;
         end else begin
            col_in = col_next[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= {req_tuser, req_tdata};
         s1_last_ff <= req_tlast;
         s1_row_ff  <= row_ff;
      end
   end

   egmgb_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff)
   );

   // A read that meets the retiring write at the same entry takes the new value.
   assign same_addr = s1_fire && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (accept) begin
         fwd_ff <= same_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_data_ff <= s1_pix_ff;
      end
   end

   assign up_pix = fwd_ff ? fwd_data_ff : ram_rd_data;

   always_comb begin
      win.tl = ul_ff;
      win.tr = up_pix;
      win.bl = ll_ff;
      win.br = s1_pix_ff;
   end

   egmgb_score u_score (
      .win    (win),
      .result (win_score)
   );

   // A window closes only past the first row and past the first column.
   always_comb begin
      max_in = max_ff;
      if (s1_row_ff && (s1_col_ff != '0) && win_score.hit && (win_score.score > max_ff)) begin
         max_in = win_score.score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ul_ff        <= '0;
         ll_ff        <= '0;
         max_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_fire) begin
            if (s1_last_ff) begin
               ul_ff  <= '0;
               ll_ff  <= '0;
               max_ff <= '0;
            end else begin
               ul_ff  <= up_pix;
               ll_ff  <= s1_pix_ff;
               max_ff <= max_in;
            end
         end
         if (s1_fire && s1_last_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         out_score_ff <= max_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_score_ff};

   // A pixel read at the entry being written sees the written value.
   `EGMGB_ASSERT_NEXT(a_fwd_value, clock, reset, accept && same_addr, up_pix == $past(s1_pix_ff))
   // Reads and writes to different entries never use the forwarding path.
   `EGMGB_ASSERT_NEXT(a_fwd_only_same, clock, reset, accept && !same_addr, !fwd_ff)
   // A retiring frame end always produces a result and clears the maximum.
   `EGMGB_ASSERT_NEXT(a_frame_clear, clock, reset, s1_fire && s1_last_ff,
                      out_valid_ff && (max_ff == '0))
   // A frame-end pixel restarts the column count and the row flag.
   `EGMGB_ASSERT_NEXT(a_frame_restart, clock, reset, accept && req_tlast,
                      (col_ff == '0) && !row_ff)
   // The compare stage never holds an item the handshake could overwrite.
   `EGMGB_ASSERT_NOW(a_no_overrun, clock, reset, accept, !s1_valid_ff || s1_fire)

endmodule

### test/tb.sv
// Self-checking testbench for edge_gated_max_gradient_blur: directed frames, then random
// frames under random stalls on both channels, checked against an in-bench score predictor.
// Depends on egmgb_pkg and the block's RTL.
module tb;
   import egmgb_pkg::*;

   localparam int MAX_W        = DEFAULT_MAX_WIDTH;
   localparam int WIDE_ITEMS   = 24;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DRAIN_CYCLES = 6;
   localparam int END_CYCLES   = 16;
   localparam int CYCLE_LIMIT  = 600000;

   typedef enum logic {ROW_PIXEL, ROW_WIDTH} row_kind_type;

   // One directed step: either a pixel item or a row width write.
   typedef struct packed {
      row_kind_type       kind;
      logic [CSR_W-1:0]   value;      // gray value or row width
      logic               edge_bit;
      logic               frame_end;
      logic               typed;      // score below is known by hand
      logic [SCORE_W-1:0] score;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 29;

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // Single pixel frame right after reset: no window, score zero.
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b1, 1'b1, 7'd0},
      // Width 0 acts as 2. Full-swing vertical and horizontal steps give the top score.
      '{ROW_WIDTH, 13'd0,   1'b0, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd0,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b1, 1'b1, 7'd127},
      // Width 1 also acts as 2. Diagonal-only window scores 85; a stronger
      // window with one edge flag clear must not count.
      '{ROW_WIDTH, 13'd1,   1'b0, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd0,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd0,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd0,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b0, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd0,   1'b1, 1'b1, 1'b1, 7'd85},
      // Width 3, frame ending in the middle of the second row.
      '{ROW_WIDTH, 13'd3,   1'b0, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd7,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd100, 1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd30,  1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd60,  1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd250, 1'b1, 1'b1, 1'b0, 7'd0},
      // Frame ending on the first column: no window is closed.
      '{ROW_PIXEL, 13'd5,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd9,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd13,  1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd200, 1'b1, 1'b1, 1'b1, 7'd0},
      // The next frame may start while the line entry of column 0 is being written.
      '{ROW_PIXEL, 13'd77,  1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd3,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd140, 1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd9,   1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd90,  1'b1, 1'b0, 1'b0, 7'd0},
      '{ROW_PIXEL, 13'd255, 1'b1, 1'b1, 1'b0, 7'd0}
   };

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [7:0]         req_tdata   = '0;    // [7:0] gray_pixel
   logic               req_tuser   = 1'b0;  // [0] edge_flag
   logic               req_tlast   = 1'b0;  // frame_end
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [7:0]         rsp_tdata;           // [6:0] blur_score, [7] zero
   logic               csr_wr_en   = 1'b0;
   logic [CSR_W-1:0]   csr_wr_data = '0;

   // Predicted frame state.
   logic [PIX_W-1:0]   line_mem [MAX_W];
   logic [PIX_W-1:0]   upper_left_q     = '0;
   logic [PIX_W-1:0]   lower_left_q     = '0;
   int unsigned        col_q            = 0;
   bit                 past_first_row_q = 1'b0;
   logic [SCORE_W-1:0] running_max_q    = '0;
   logic [CSR_W-1:0]   line_width_q     = LINE_WIDTH_RESET;
   int unsigned        written_limit    = 0;  // line entries below this were written

   logic [SCORE_W-1:0] pending_scores [$];
   logic [SCORE_W-1:0] oldest_score;
   int                 failures   = 0;
   int unsigned        cycle_count;
   bit                 fast_mode  = 1'b0;     // both sides run without idling

   edge_gated_max_gradient_blur dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned effective_width(input logic [CSR_W-1:0] w);
      if (w < MIN_LINE_WIDTH) return MIN_LINE_WIDTH;
      if (w > MAX_W) return MAX_W;
      return 32'(w);
   endfunction

   function automatic logic [SCORE_W-1:0] gradient_score(input logic [7:0] tl, tr, bl, br);
      int a, b, best, s;
      a = tl;
      b = bl;
      best = (a > b ? a - b : b - a) / 2;
      b = tr;
      s = (a > b ? a - b : b - a) / 2;
      if (s > best) best = s;
      b = br;
      s = (a > b ? a - b : b - a) / 3;
      if (s > best) best = s;
      return SCORE_W'(best);
   endfunction

   // Advances the predicted state by one accepted pixel; on a frame end it returns
   // the frame's score and clears the window, column, row flag and running maximum.
   task automatic advance_blur_state(input logic [7:0] gray, input logic edge_bit,
                                     input logic frame_end, output bit produced,
                                     output logic [SCORE_W-1:0] score);
      logic [PIX_W-1:0] pix, up;
      logic [SCORE_W-1:0] s;
      int unsigned w;
      pix = {edge_bit, gray};
      w = effective_width(line_width_q);
      up = line_mem[col_q];
      if (past_first_row_q && col_q >= 1 &&
          upper_left_q[PIX_W-1] && up[PIX_W-1] && lower_left_q[PIX_W-1] && edge_bit) begin
         s = gradient_score(upper_left_q[7:0], up[7:0], lower_left_q[7:0], gray);
         if (s > running_max_q) running_max_q = s;
      end
      upper_left_q = up;
      lower_left_q = pix;
      line_mem[col_q] = pix;
      if (col_q + 1 > written_limit) written_limit = col_q + 1;
      col_q++;
      if (col_q >= w) begin
         col_q = 0;
         past_first_row_q = 1'b1;
      end
      produced = frame_end;
      score = running_max_q;
      if (frame_end) begin
         upper_left_q = '0;
         lower_left_q = '0;
         col_q = 0;
         past_first_row_q = 1'b0;
         running_max_q = '0;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pixel(input logic [7:0] gray, input logic edge_bit,
                             input logic frame_end, input bit typed,
                             input logic [SCORE_W-1:0] typed_score);
      int unsigned gap;
      bit produced;
      logic [SCORE_W-1:0] predicted;
      gap = fast_mode ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= gray;
      req_tuser  <= edge_bit;
      req_tlast  <= frame_end;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      advance_blur_state(gray, edge_bit, frame_end, produced, predicted);
      if (produced) pending_scores.push_back(typed ? typed_score : predicted);
      @(negedge clock);
   endtask

   // Holds the sender off until every score is back and the pipeline is empty.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_scores.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_width(input logic [CSR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      line_width_q = value;
   endtask

   // Mostly small rows, with the clamp extremes and a few wider rows mixed in.
   function automatic logic [CSR_W-1:0] pick_width();
      case ($urandom_range(0, 19))
         0: return CSR_W'(0);
         1: return CSR_W'(1);
         2: return CSR_W'(MAX_W);
         3: return CSR_W'(MAX_W + 1);
         4: return '1;
         5: return CSR_W'($urandom_range(13, 64));
         default: return CSR_W'($urandom_range(2, 12));
      endcase
   endfunction

   function automatic logic [7:0] pick_gray();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Scores are compared as the receiver accepts them.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $error("blur_score expected none actual %0d", rsp_tdata[SCORE_W-1:0]);
            failures++;
         end else begin
            oldest_score = pending_scores.pop_front();
            if (rsp_tdata[SCORE_W-1:0] !== oldest_score) begin
               $error("blur_score expected %0d actual %0d", oldest_score,
                      rsp_tdata[SCORE_W-1:0]);
               failures++;
            end
         end
      end
   end

   // Receiver: per score, either ready ahead of time or a stall after valid shows.
   initial begin : score_sink
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = fast_mode ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[edge_gated_max_gradient_blur] ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned random_items, len, change_at, w, edge_pct, i;
      logic [CSR_W-1:0] next_width;
      foreach (line_mem[k]) line_mem[k] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         if (directed_rows[k].kind == ROW_WIDTH) begin
            drain_block();
            program_width(directed_rows[k].value);
         end else begin
            send_pixel(directed_rows[k].value[7:0], directed_rows[k].edge_bit,
                       directed_rows[k].frame_end, directed_rows[k].typed,
                       directed_rows[k].score);
         end
      end

      // One short frame at the widest row: the all-ones width clamps to the line
      // memory size.
      drain_block();
      program_width('1);
      for (i = 0; i < WIDE_ITEMS; i++)
         send_pixel(pick_gray(), 1'b1, i == WIDE_ITEMS - 1, 1'b0, '0);

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         fast_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 7) == 0) drain_block();
         if ($urandom_range(0, 9) < 4) begin
            drain_block();
            program_width(pick_width());
         end
         w = effective_width(line_width_q);
         case ($urandom_range(0, 2))
            0: edge_pct = 100;
            1: edge_pct = 90;
            default: edge_pct = 50;
         endcase
         // Wide rows only get short partial frames; narrow rows get whole rows
         // plus a ragged tail, and now and then a stray one- to three-pixel frame.
         if (w > 64) len = $urandom_range(1, 24);
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 3);
         else len = w * $urandom_range(1, 5) + $urandom_range(0, w - 1);
         change_at = (len > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, len - 1)
                                                             : len;
         for (i = 0; i < len; i++) begin
            if (i == change_at) begin
               // A new width mid-row takes effect at once. Growing past the part
               // of the line memory written so far is kept to the first row.
               next_width = pick_width();
               if (past_first_row_q && effective_width(next_width) > written_limit)
                  next_width = CSR_W'(written_limit);
               drain_block();
               program_width(next_width);
            end
            send_pixel(pick_gray(), $urandom_range(0, 99) < edge_pct, i == len - 1,
                       1'b0, '0);
            random_items++;
         end
      end

      fast_mode = 1'b0;
      drain_block();
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0 && pending_scores.size() == 0)
         $display("[edge_gated_max_gradient_blur] OK");
      else
         $display("[edge_gated_max_gradient_blur] ERROR");
      $finish;
   end

endmodule
